// ===== sv/adsre_pkg.sv =====
// Shared types and constants for the ADSR envelope generator with echo tail.
// Used by the controller, the datapath and the top level; depends on nothing.
package adsre_pkg;

  // Fixed field widths of the stream items.
  localparam int CH_W       = 4;
  localparam int BYTE_W     = 8;
  localparam int OP_W       = 2;
  localparam int VOL_W      = 4;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 32;

  localparam logic [BYTE_W-1:0] LEVEL_MAX = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_RELEASE = 2'd0,
    PH_SUSTAIN = 2'd1,
    PH_DECAY   = 2'd2,
    PH_ATTACK  = 2'd3
  } phase_e;

  typedef struct packed {
    logic echo;
    logic stop;
    logic start;
    logic on;
  } chan_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_SCALE = 2'd2,
    ST_MIX   = 2'd3
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic scale;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/adsr_envelope_with_echo.sv =====
// Top level of the per-channel ADSR envelope generator with echo tail.
// Depends on adsre_pkg, adsre_ctrl and adsre_dp.

// Each request on the input stream is a start, release or tick for one
// channel. Start and release requests are accepted, then applied in the
// state update, and give no result; the unused operation code behaves the
// same way. A tick request is accepted, then goes through the envelope
// update, which shares one 8x8 multiplier between decay and release, then
// the master volume multiply, and then the left and right mix multiply,
// whose result is loaded into the output register. The input accepts a new
// request as soon as the controller is back in its idle state, even while
// an earlier result still waits in the output register; a tick only stalls
// in its last step if that register is still full. There is no clearing
// pass after reset: the channel flags, phases and levels reset at once, and
// a tick only uses the settings memories of a channel after a start has
// written them. The master volume register may be written at any time the
// block holds no request in flight, and its write channel is always ready.
// Level, left and right outputs of a channel that is silent or freed by the
// tick are zero.
module adsr_envelope_with_echo #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: channel[3:0], attack_step, decay_factor, sustain_level,
  // release_factor, echo_level, echo_ticks, right_level, left_level, zero fill.
  input  logic [adsre_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0: operation[1:0].
  input  logic [adsre_pkg::OP_W-1:0]          s_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  // master_volume[3:0].
  input  logic [adsre_pkg::VOL_W-1:0]         cfg_data_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: channel_out[3:0], envelope_level, right_out, left_out,
  // zero fill.
  output logic [adsre_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0: active.
  output logic                                m_axis_tuser
);

  adsre_pkg::ctrl_cmd_t  cmd;
  adsre_pkg::dp_status_t status;

  // The volume register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  adsre_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  adsre_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

// ===== sv/adsre_ctrl.sv =====
// Sequencing state machine of the envelope generator.
// Depends on adsre_pkg; drives the datapath through ctrl_cmd_t commands only.
module adsre_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  adsre_pkg::dp_status_t  status_i,
  output adsre_pkg::ctrl_cmd_t   cmd_o
);

  adsre_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adsre_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      adsre_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = adsre_pkg::ST_EXEC;
        end
      end
      adsre_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.is_tick ? adsre_pkg::ST_SCALE : adsre_pkg::ST_IDLE;
      end
      adsre_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = adsre_pkg::ST_MIX;
      end
      adsre_pkg::ST_MIX: begin
        // Hold the finished mix until the output register can take it.
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = adsre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = adsre_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/adsre_dp.sv =====
// Datapath of the envelope generator: channel state, settings memories,
// envelope update, master and mix scaling, output register. Uses adsre_pkg.
module adsre_dp #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [adsre_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic [adsre_pkg::OP_W-1:0]           s_tuser_i,
  input  logic                                 cfg_valid_i,
  input  logic [adsre_pkg::VOL_W-1:0]          cfg_data_i,
  input  adsre_pkg::ctrl_cmd_t                 cmd_i,
  output adsre_pkg::dp_status_t                status_o,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [adsre_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic                                 m_tuser_o
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int BW    = adsre_pkg::BYTE_W;
  localparam int CW    = adsre_pkg::CH_W;

  // Captured item.
  logic [adsre_pkg::OP_W-1:0] op_q;
  logic [CW-1:0]              ch_q;
  logic [BW-1:0]              attack_q, decay_q, sustain_q, release_q;
  logic [BW-1:0]              echo_lvl_in_q, echo_ticks_in_q, right_q, left_q;

  // Per-channel state.
  adsre_pkg::chan_flags_t flags_q [NUM_CHANNELS];
  adsre_pkg::phase_e      phase_q [NUM_CHANNELS];
  logic [BW-1:0]          level_q [NUM_CHANNELS];

  // Settings memories, undefined until a start writes them.
  logic [4*BW-1:0] adsr_mem [NUM_CHANNELS];
  logic [2*BW-1:0] echo_mem [NUM_CHANNELS];
  logic [4*BW-1:0] adsr_rd_q;
  logic [2*BW-1:0] echo_rd_q;

  logic [adsre_pkg::VOL_W-1:0] master_vol_q;
  logic                        act_q;
  logic [BW-1:0]               lvl_res_q;
  logic [BW-1:0]               scale_q;
  logic                        m_tvalid_q;
  logic                        m_active_q;
  logic [CW-1:0]               m_ch_q;
  logic [BW-1:0]               m_lvl_q, m_right_q, m_left_q;

  logic [IDX_W-1:0]       idx_in, idx;
  logic                   ch_valid;
  adsre_pkg::chan_flags_t cur_flags, nxt_flags;
  adsre_pkg::phase_e      cur_phase, nxt_phase;
  logic [BW-1:0]          cur_level, nxt_level;
  logic [BW-1:0]          s_attack, s_decay, s_sustain, s_release, echo_lvl, echo_cnt;
  logic [BW-1:0]          echo_left, factor, prod_hi, base_level;
  logic [2*BW-1:0]        prod;
  logic [BW:0]            attack_sum;
  logic                   tick_act, echo_wr;
  logic [adsre_pkg::VOL_W:0] vol_plus;
  logic [BW+4:0]          scale_prod;
  logic [2*BW-1:0]        right_prod, left_prod;

  assign idx_in   = s_tdata_i[IDX_W-1:0];
  assign idx      = ch_q[IDX_W-1:0];
  assign ch_valid = ({1'b0, ch_q} < (CW+1)'(NUM_CHANNELS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q            <= s_tuser_i;
      ch_q            <= s_tdata_i[CW-1:0];
      attack_q        <= s_tdata_i[CW+0*BW +: BW];
      decay_q         <= s_tdata_i[CW+1*BW +: BW];
      sustain_q       <= s_tdata_i[CW+2*BW +: BW];
      release_q       <= s_tdata_i[CW+3*BW +: BW];
      echo_lvl_in_q   <= s_tdata_i[CW+4*BW +: BW];
      echo_ticks_in_q <= s_tdata_i[CW+5*BW +: BW];
      right_q         <= s_tdata_i[CW+6*BW +: BW];
      left_q          <= s_tdata_i[CW+7*BW +: BW];
      adsr_rd_q       <= adsr_mem[idx_in];
      echo_rd_q       <= echo_mem[idx_in];
    end
  end

  assign cur_flags = flags_q[idx];
  assign cur_phase = phase_q[idx];
  assign cur_level = level_q[idx];
  assign s_attack  = adsr_rd_q[0*BW +: BW];
  assign s_decay   = adsr_rd_q[1*BW +: BW];
  assign s_sustain = adsr_rd_q[2*BW +: BW];
  assign s_release = adsr_rd_q[3*BW +: BW];
  assign echo_lvl  = echo_rd_q[0 +: BW];
  assign echo_cnt  = echo_rd_q[BW +: BW];
  assign echo_left = echo_cnt - BW'(1);

  // One shared multiplier for decay and release.
  assign factor     = cur_flags.stop ? s_release : s_decay;
  assign prod       = cur_level * factor;
  assign prod_hi    = prod[2*BW-1:BW];
  assign base_level = cur_flags.start ? '0 : cur_level;
  assign attack_sum = {1'b0, base_level} + {1'b0, s_attack};

  always_comb begin
    nxt_flags = cur_flags;
    nxt_phase = cur_phase;
    nxt_level = cur_level;
    tick_act  = 1'b0;
    echo_wr   = 1'b0;
    priority if (!ch_valid || !cur_flags.on) begin
      tick_act = 1'b0;
    end else if (cur_flags.start && cur_flags.stop) begin
      nxt_flags = '0;
      nxt_level = '0;
    end else if (cur_flags.start || (!cur_flags.echo && !cur_flags.stop &&
                                     cur_phase == adsre_pkg::PH_ATTACK)) begin
      // Attack step; a fresh start begins from zero.
      tick_act       = 1'b1;
      nxt_flags      = '0;
      nxt_flags.on   = 1'b1;
      if (attack_sum >= {1'b0, adsre_pkg::LEVEL_MAX}) begin
        nxt_level = adsre_pkg::LEVEL_MAX;
        nxt_phase = adsre_pkg::PH_DECAY;
      end else begin
        nxt_level = attack_sum[BW-1:0];
        nxt_phase = adsre_pkg::PH_ATTACK;
      end
    end else if (cur_flags.echo) begin
      echo_wr = 1'b1;
      if (echo_left == '0) begin
        nxt_flags = '0;
        nxt_level = '0;
      end else begin
        tick_act = 1'b1;
      end
    end else if (cur_flags.stop) begin
      tick_act  = 1'b1;
      nxt_level = prod_hi;
      if (prod_hi <= echo_lvl) begin
        if (echo_lvl == '0) begin
          tick_act  = 1'b0;
          nxt_flags = '0;
          nxt_level = '0;
        end else begin
          nxt_level      = echo_lvl;
          nxt_flags.echo = 1'b1;
        end
      end
    end else if (cur_phase == adsre_pkg::PH_DECAY) begin
      tick_act  = 1'b1;
      nxt_level = prod_hi;
      if (prod_hi <= s_sustain) begin
        nxt_level = s_sustain;
        if (s_sustain != '0) begin
          nxt_phase = adsre_pkg::PH_SUSTAIN;
        end else if (echo_lvl == '0) begin
          tick_act  = 1'b0;
          nxt_flags = '0;
          nxt_level = '0;
        end else begin
          nxt_level      = echo_lvl;
          nxt_flags.echo = 1'b1;
        end
      end
    end else begin
      // Sustain, or release phase without stop: level held.
      tick_act = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        flags_q[i] <= '0;
        phase_q[i] <= adsre_pkg::PH_RELEASE;
        level_q[i] <= '0;
      end
    end else if (cmd_i.exec && ch_valid) begin
      unique case (adsre_pkg::op_e'(op_q))
        adsre_pkg::OP_START: begin
          flags_q[idx] <= adsre_pkg::chan_flags_t'{echo: 1'b0, stop: 1'b0,
                                                   start: 1'b1, on: 1'b1};
        end
        adsre_pkg::OP_RELEASE: begin
          if (cur_flags.on) begin
            flags_q[idx].stop <= 1'b1;
          end
        end
        adsre_pkg::OP_TICK: begin
          flags_q[idx] <= nxt_flags;
          phase_q[idx] <= nxt_phase;
          level_q[idx] <= nxt_level;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ch_valid) begin
      if (adsre_pkg::op_e'(op_q) == adsre_pkg::OP_START) begin
        adsr_mem[idx] <= {release_q, sustain_q, decay_q, attack_q};
        echo_mem[idx] <= {echo_ticks_in_q, echo_lvl_in_q};
      end else if (adsre_pkg::op_e'(op_q) == adsre_pkg::OP_TICK && echo_wr) begin
        echo_mem[idx] <= {echo_left, echo_lvl};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_vol_q <= '1;
    end else if (cfg_valid_i) begin
      master_vol_q <= cfg_data_i;
    end
  end

  // Result of the tick, then master scaling, then the left and right mix.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      act_q     <= tick_act;
      lvl_res_q <= tick_act ? nxt_level : '0;
    end
    if (cmd_i.scale) begin
      scale_q <= scale_prod[BW+3:4];
    end
  end

  assign vol_plus   = (adsre_pkg::VOL_W+1)'(master_vol_q) + (adsre_pkg::VOL_W+1)'(1);
  assign scale_prod = (BW+5)'(vol_plus) * (BW+5)'(lvl_res_q);
  assign right_prod = right_q * scale_q;
  assign left_prod  = left_q * scale_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      m_ch_q     <= ch_q;
      m_active_q <= act_q;
      m_lvl_q    <= lvl_res_q;
      // The product never exceeds 254 in its upper byte, so it is already saturated.
      m_right_q  <= right_prod[2*BW-1:BW];
      m_left_q   <= left_prod[2*BW-1:BW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  assign status_o.is_tick  = (adsre_pkg::op_e'(op_q) == adsre_pkg::OP_TICK);
  assign status_o.out_free = !m_tvalid_q || m_tready_i;

  assign m_tvalid_o = m_tvalid_q;
  assign m_tuser_o  = m_active_q;
  assign m_tdata_o  = {(adsre_pkg::OUT_TDATA_W - CW - 3*BW)'(0),
                       m_left_q, m_right_q, m_lvl_q, m_ch_q};

endmodule

// ===== sv/adsre_checker.sv =====
// Port-level checks for the envelope generator, bound to the top level.
// Depends on adsre_pkg and on adsr_envelope_with_echo's port names.
module adsre_checker #(
  parameter int NUM_CHANNELS = 12
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [adsre_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                               m_axis_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A silent channel reports zero level and zero mix.
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[27:4] == 24'd0)
    else $error("inactive result carries a level");

  // Only a channel that exists can be sounding.
  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> {1'b0, m_axis_tdata[3:0]} < 5'(NUM_CHANNELS))
    else $error("active result on a channel out of range");

  // Mixed levels never exceed the envelope level.
  a_mix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:12] <= m_axis_tdata[11:4] &&
                      m_axis_tdata[27:20] <= m_axis_tdata[11:4])
    else $error("mix level above envelope level");

  // One request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted back to back");

endmodule

bind adsr_envelope_with_echo adsre_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_adsre_checker (.*);

// ===== verif/adsre_envelope_checker.sv =====
`timescale 1ns / 100ps
// Watches the request, result and volume channels of the ADSR envelope block.
// It predicts every tick report and compares it. Depends on adsre_pkg only.
module adsre_envelope_checker #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [adsre_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [adsre_pkg::OP_W-1:0]       s_axis_tuser,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [adsre_pkg::VOL_W-1:0]      cfg_data_i,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [adsre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             m_axis_tuser,
  output int                               fail_count_o,
  output int                               pending_o
);
  import adsre_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]   chan;
    logic              active;
    logic [BYTE_W-1:0] level;
    logic [BYTE_W-1:0] right;
    logic [BYTE_W-1:0] left;
  } tick_report_t;

  // Model of the per-channel envelope state.
  logic [BYTE_W-1:0] env_level      [NUM_CHANNELS];
  phase_e            env_phase      [NUM_CHANNELS];
  chan_flags_t       voice_flags    [NUM_CHANNELS];
  logic [BYTE_W-1:0] attack_step    [NUM_CHANNELS];
  logic [BYTE_W-1:0] decay_factor   [NUM_CHANNELS];
  logic [BYTE_W-1:0] sustain_level  [NUM_CHANNELS];
  logic [BYTE_W-1:0] release_factor [NUM_CHANNELS];
  logic [BYTE_W-1:0] echo_level     [NUM_CHANNELS];
  logic [BYTE_W-1:0] echo_left      [NUM_CHANNELS];
  logic [VOL_W-1:0]  master_volume;

  tick_report_t expected_reports[$];

  function automatic void free_voice(int c);
    voice_flags[c] = '0;
    env_level[c]   = '0;
  endfunction

  // Holds the echo level, or frees the channel when that level is zero.
  function automatic bit enter_echo(int c);
    if (echo_level[c] == '0) begin
      free_voice(c);
      return 1'b0;
    end
    env_level[c]        = echo_level[c];
    voice_flags[c].echo = 1'b1;
    return 1'b1;
  endfunction

  // One envelope step for channel c; returns whether it still sounds.
  function automatic bit advance_envelope(int c);
    int unsigned lvl;
    lvl = env_level[c];
    if (!voice_flags[c].on) return 1'b0;
    if (voice_flags[c].start) begin
      if (voice_flags[c].stop) begin
        free_voice(c);
        return 1'b0;
      end
      voice_flags[c]    = '0;
      voice_flags[c].on = 1'b1;
      env_phase[c]      = PH_ATTACK;
      lvl               = 0;
    end else if (voice_flags[c].echo) begin
      // The hold counter is eight bits wide, so a length of zero wraps.
      echo_left[c] = echo_left[c] - 8'd1;
      if (echo_left[c] == '0) begin
        free_voice(c);
        return 1'b0;
      end
      return 1'b1;
    end else if (voice_flags[c].stop) begin
      lvl = (lvl * release_factor[c]) >> 8;
      if (lvl <= echo_level[c]) return enter_echo(c);
      env_level[c] = BYTE_W'(lvl);
      return 1'b1;
    end else if (env_phase[c] == PH_DECAY) begin
      lvl = (lvl * decay_factor[c]) >> 8;
      if (lvl <= sustain_level[c]) begin
        if (sustain_level[c] == '0) return enter_echo(c);
        lvl          = sustain_level[c];
        env_phase[c] = PH_SUSTAIN;
      end
      env_level[c] = BYTE_W'(lvl);
      return 1'b1;
    end else if (env_phase[c] != PH_ATTACK) begin
      return 1'b1;
    end
    lvl = lvl + attack_step[c];
    if (lvl >= LEVEL_MAX) begin
      lvl          = LEVEL_MAX;
      env_phase[c] = PH_DECAY;
    end
    env_level[c] = BYTE_W'(lvl);
    return 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] mix_level(logic [BYTE_W-1:0] pan,
                                                  logic [BYTE_W-1:0] lvl);
    int unsigned scale;
    int unsigned mixed;
    scale = ((32'(master_volume) + 32'd1) * 32'(lvl)) >> 4;
    mixed = (32'(pan) * scale) >> 8;
    return (mixed > LEVEL_MAX) ? LEVEL_MAX : BYTE_W'(mixed);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_report_t got;
    tick_report_t want;
    int           c;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        env_level[i]   = '0;
        env_phase[i]   = PH_RELEASE;
        voice_flags[i] = '0;
      end
      master_volume = 4'hF;
      expected_reports.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.chan   = m_axis_tdata[3:0];
        got.level  = m_axis_tdata[11:4];
        got.right  = m_axis_tdata[19:12];
        got.left   = m_axis_tdata[27:20];
        got.active = m_axis_tuser;
        if (expected_reports.size() == 0) begin
          $error("result for channel %0d arrived with nothing expected", got.chan);
          fail_count_o++;
        end else begin
          want = expected_reports.pop_front();
          check_field("channel_out", want.chan, got.chan);
          check_field("active", want.active, got.active);
          check_field("envelope_level", want.level, got.level);
          check_field("right_out", want.right, got.right);
          check_field("left_out", want.left, got.left);
        end
      end

      if (cfg_valid_i && cfg_ready_o) master_volume = cfg_data_i;

      if (s_axis_tvalid && s_axis_tready) begin
        c = s_axis_tdata[3:0];
        case (s_axis_tuser)
          OP_START: begin
            if (c < NUM_CHANNELS) begin
              attack_step[c]       = s_axis_tdata[11:4];
              decay_factor[c]      = s_axis_tdata[19:12];
              sustain_level[c]     = s_axis_tdata[27:20];
              release_factor[c]    = s_axis_tdata[35:28];
              echo_level[c]        = s_axis_tdata[43:36];
              echo_left[c]         = s_axis_tdata[51:44];
              voice_flags[c]       = '0;
              voice_flags[c].on    = 1'b1;
              voice_flags[c].start = 1'b1;
            end
          end
          OP_RELEASE: begin
            if (c < NUM_CHANNELS && voice_flags[c].on) voice_flags[c].stop = 1'b1;
          end
          OP_TICK: begin
            want        = '0;
            want.chan   = CH_W'(c);
            want.active = (c < NUM_CHANNELS) ? advance_envelope(c) : 1'b0;
            if (want.active) begin
              want.level = env_level[c];
              want.right = mix_level(s_axis_tdata[59:52], env_level[c]);
              want.left  = mix_level(s_axis_tdata[67:60], env_level[c]);
            end
            expected_reports.push_back(want);
          end
          default: ;  // The spare operation code is dropped silently.
        endcase
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the testbench for adsr_envelope_with_echo: clock, reset, stimulus and verdict.
// Depends on adsre_pkg, the block itself and adsre_envelope_checker.
module testbench;
  import adsre_pkg::*;

  localparam int NUM_CH         = 12;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RX_HOLD_CYCLES = 300;
  // Settling time allowed after the last result before anything else moves.
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [VOL_W-1:0] VOL_MIN   = 4'h0;
  localparam logic [VOL_W-1:0] VOL_MAX   = 4'hF;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = '0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [VOL_W-1:0]       cfg_data_i    = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int fail_count;
  int pending;
  int cycles        = 0;
  int requests_sent = 0;
  bit no_gaps       = 1'b0;  // Both sides run flat out while this is set.
  bit rx_hold       = 1'b0;  // Asks the result side for one long stall.

  always #5 clk_i = ~clk_i;

  adsr_envelope_with_echo #(
    .NUM_CHANNELS(NUM_CH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  adsre_envelope_checker #(
    .NUM_CHANNELS(NUM_CH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side. Each result is preceded by a random stall unless the
  // flat-out mode is on; a pending hold request stops it for a long stretch,
  // during which the block fills up and must push back on its input.
  initial begin : result_sink
    int stall;
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Leans towards the ends of the byte range, where the arithmetic saturates.
  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return any_byte();
    endcase
  endfunction

  // Mostly short echo holds so that notes run to the end; now and then any.
  function automatic logic [7:0] echo_length();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 8)) : edgy_byte();
  endfunction

  // Presents one request after a random gap and waits for its acceptance.
  // Valid is left high so that back-to-back requests need no extra edge.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                              input logic [7:0] att, input logic [7:0] dec,
                              input logic [7:0] sus, input logic [7:0] rel,
                              input logic [7:0] echo_lvl, input logic [7:0] echo_len,
                              input logic [7:0] pan_r, input logic [7:0] pan_l);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, pan_l, pan_r, echo_len, echo_lvl, rel, sus, dec, att, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    // Requests that the block simply drops are not counted.
    if (op == OP_TICK || (op != OP_UNUSED && ch < NUM_CH)) requests_sent++;
  endtask

  task automatic send_start(input logic [CH_W-1:0] ch, input logic [7:0] att,
                            input logic [7:0] dec, input logic [7:0] sus,
                            input logic [7:0] rel, input logic [7:0] echo_lvl,
                            input logic [7:0] echo_len);
    send_request(OP_START, ch, att, dec, sus, rel, echo_lvl, echo_len,
                 any_byte(), any_byte());
  endtask

  task automatic send_release(input logic [CH_W-1:0] ch);
    send_request(OP_RELEASE, ch, any_byte(), any_byte(), any_byte(), any_byte(),
                 any_byte(), any_byte(), any_byte(), any_byte());
  endtask

  task automatic send_tick(input logic [CH_W-1:0] ch, input logic [7:0] pan_r,
                           input logic [7:0] pan_l);
    send_request(OP_TICK, ch, any_byte(), any_byte(), any_byte(), any_byte(),
                 any_byte(), any_byte(), pan_r, pan_l);
  endtask

  // A stray request of any kind, a quarter of them on a channel that does
  // not exist.
  task automatic maybe_noise(input int percent);
    logic [CH_W-1:0] ch;
    if ($urandom_range(0, 99) < percent) begin
      ch = ($urandom_range(0, 3) == 0) ? CH_W'($urandom_range(NUM_CH, 15))
                                       : CH_W'($urandom_range(0, NUM_CH - 1));
      send_request(OP_W'($urandom_range(0, 3)), ch, any_byte(), any_byte(),
                   any_byte(), any_byte(), any_byte(), any_byte(), any_byte(),
                   any_byte());
    end
  endtask

  // One well-formed note: start, some ticks, usually a release, then ticks
  // through the release and echo tail, with stray requests mixed in.
  task automatic play_note(input int top_ch, input int noise_percent);
    logic [CH_W-1:0] ch;
    ch = CH_W'($urandom_range(0, top_ch));
    send_start(ch, edgy_byte(), edgy_byte(), edgy_byte(), edgy_byte(), edgy_byte(),
               echo_length());
    repeat ($urandom_range(0, 14)) begin
      maybe_noise(noise_percent);
      send_tick(ch, edgy_byte(), edgy_byte());
    end
    if ($urandom_range(0, 7) != 0) send_release(ch);
    repeat ($urandom_range(0, 16)) begin
      maybe_noise(noise_percent);
      send_tick(ch, edgy_byte(), edgy_byte());
    end
  endtask

  task automatic write_volume(input logic [VOL_W-1:0] vol);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= vol;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering requests and waits until every expected result is in,
  // then lets the block settle. Checked on the falling edge, clear of the
  // checker's updates.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_volume(VOL_MAX);

    // Attack overflows at once, then decay meets a zero sustain with no
    // echo, which frees the channel; the next tick finds it silent.
    send_start(4'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255);
    send_tick(4'd0, 8'd255, 8'd255);
    send_tick(4'd0, 8'd255, 8'd255);
    send_tick(4'd0, 8'd0, 8'd0);
    // Released before its first tick: that tick frees it.
    send_start(4'd1, 8'd16, 8'd240, 8'd128, 8'd128, 8'd32, 8'd2);
    send_release(4'd1);
    send_tick(4'd1, 8'd200, 8'd100);
    // Release on a silent channel is ignored.
    send_release(4'd2);
    send_tick(4'd2, 8'd255, 8'd255);
    // Channel index beyond the last channel, and the spare operation code.
    send_start(4'd15, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_release(4'd15);
    send_tick(4'd15, 8'd255, 8'd255);
    send_request(OP_UNUSED, 4'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                 8'd255, 8'd255);
    // Full sustain, then a release straight into a one-tick echo hold.
    send_start(4'd11, 8'd200, 8'd255, 8'd255, 8'd0, 8'd255, 8'd1);
    repeat (4) send_tick(4'd11, 8'd255, 8'd128);
    send_release(4'd11);
    send_tick(4'd11, 8'd255, 8'd255);
    send_tick(4'd11, 8'd255, 8'd255);
    // Zero sustain with an echo level, then a restart while still sounding.
    send_start(4'd4, 8'd255, 8'd0, 8'd0, 8'd64, 8'd50, 8'd3);
    repeat (3) send_tick(4'd4, 8'd77, 8'd255);
    send_start(4'd4, 8'd100, 8'd200, 8'd60, 8'd64, 8'd20, 8'd2);
    send_tick(4'd4, 8'd255, 8'd255);

    // Lowest master volume, two channels so that notes run deep.
    drain();
    write_volume(VOL_MIN);
    while (requests_sent < 320) play_note(1, 10);

    // Mid volume; the result side stalls at length while requests keep
    // coming, and both sides first run without gaps.
    drain();
    write_volume(VOL_W'($urandom_range(1, 14)));
    rx_hold = 1'b1;
    no_gaps = 1'b1;
    while (requests_sent < 480) play_note(3, 15);
    no_gaps = 1'b0;
    while (requests_sent < 650) play_note(3, 15);

    // Full volume. An echo length of zero wraps and holds for 255 ticks.
    drain();
    write_volume(VOL_MAX);
    send_start(4'd5, 8'd255, 8'd128, 8'd100, 8'd0, 8'd77, 8'd0);
    repeat (3) send_tick(4'd5, edgy_byte(), edgy_byte());
    send_release(4'd5);
    repeat (258) send_tick(4'd5, edgy_byte(), edgy_byte());
    while (requests_sent < 1200) play_note(NUM_CH - 1, 10);

    // Any volume, every channel, heavy noise and broken notes.
    drain();
    write_volume(VOL_W'($urandom_range(0, 15)));
    while (requests_sent < 1550) play_note(NUM_CH - 1, 50);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
